// ===== hdl/wbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int PATTERN_MAX    = 32;
	localparam int OFFSET_BITS    = 32;
	localparam int LEN_BITS       = 6;
	localparam int IDX_BITS       = $clog2(PATTERN_MAX);
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int PAT_WORDS      = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

	typedef logic [PATTERN_MAX-1:0][7:0] window_t;
	typedef logic [OFFSET_BITS-1:0]      pos_t;
	typedef logic [LEN_BITS-1:0]         len_t;

	// one accepted byte, with the window as it stands after that byte
	typedef struct packed {
		window_t window;
		pos_t    pos;
		logic    last;
	} scan_item_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_LENGTH    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [QCNT_BITS-1:0] count;
		logic                 full;
		logic                 empty;
	} queue_stat_t;

	typedef struct packed {
		logic match_seen;
		logic pop;
		logic pop_last;
	} back_stat_t;

	// length 0 counts as 1, anything above the window as the window
	function automatic len_t eff_len(input len_t raw);
		len_t n;
		n = raw;
		if (raw == '0)
			n = len_t'(1);
		else if (raw > len_t'(PATTERN_MAX))
			n = len_t'(PATTERN_MAX);
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/wbps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_front
// Accepts image bytes, keeps the sliding window and byte position, and pushes
// one item per byte into the queue.
// ----------------------------------------------------------------------------
module wbps_front import wbps_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       q_full,
	output logic            push,
	output scan_item_t      push_item
);

	window_t window_q;
	pos_t    pos_q;
	window_t window_next;

	assign in_ready    = !q_full;
	assign push        = in_valid && in_ready;
	assign window_next = {window_q[PATTERN_MAX-2:0], data_byte};

	always_comb begin
		push_item.window = window_next;
		push_item.pos    = pos_q;
		push_item.last   = last_byte;
	end

	// newest byte in entry 0; stale entries are never compared
	always_ff @(posedge clk) begin
		if (push) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (last_byte)
				pos_q <= '0;
			else if (pos_q != '1)
				pos_q <= pos_q + pos_t'(1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wbps_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module wbps_queue import wbps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  scan_item_t       push_item,
	input  wire logic        pop,
	output scan_item_t       head,
	output queue_stat_t      stat
);

	scan_item_t           slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign head       = slots_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wbps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_back
// Holds the pattern registers, compares the queued window against the
// pattern, tracks the per-scan match flag and drives the result register.
// ----------------------------------------------------------------------------
module wbps_back import wbps_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  scan_item_t                     head,
	input  wire logic                      q_empty,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           found,
	output logic [31:0]                    match_offset,
	output back_stat_t                     stat
);

	logic [PAT_WORDS-1:0][CFG_DATA_BITS-1:0] pat_words_q;
	len_t                                    pat_len_q;
	logic                                    match_seen_q;
	logic                                    out_valid_q;
	logic                                    found_q;
	logic [31:0]                             offset_q;

	window_t                  pat_bytes;
	len_t                     len;
	len_t                     len_m1;
	len_t                     k;
	logic [PATTERN_MAX-1:0]   byte_ok;
	logic                     hit;
	logic                     emit;
	pos_t                     offset;

	assign pat_bytes = pat_words_q;
	assign len       = eff_len(pat_len_q);
	assign len_m1    = len - len_t'(1);

	// window entry j holds the byte that lines up with pattern byte len-1-j
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			k = len_m1 - len_t'(j);
			byte_ok[j] = (len_t'(j) >= len)
				|| (pat_bytes[k[IDX_BITS-1:0]] == WILDCARD_BYTE)
				|| (pat_bytes[k[IDX_BITS-1:0]] == head.window[j]);
		end
	end

	assign hit    = (&byte_ok) && (head.pos >= pos_t'(len_m1));
	assign offset = head.pos - pos_t'(len_m1);
	assign pop    = !q_empty && (!out_valid_q || out_ready);
	assign emit   = pop && !match_seen_q && (hit || head.last);

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_offset  = offset_q;
	assign stat.match_seen = match_seen_q;
	assign stat.pop        = pop;
	assign stat.pop_last   = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q <= '0;
			pat_len_q   <= len_t'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_0: pat_words_q[0] <= cfg_data;
				REG_PATTERN_1: pat_words_q[1] <= cfg_data;
				REG_PATTERN_2: pat_words_q[2] <= cfg_data;
				REG_PATTERN_3: pat_words_q[3] <= cfg_data;
				REG_LENGTH:    pat_len_q      <= cfg_data[LEN_BITS-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop)
				match_seen_q <= head.last ? 1'b0 : (match_seen_q | hit);
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q  <= hit;
			offset_q <= hit ? offset[31:0] : '0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wildcard_byte_pattern_scan_top.sv =====
`default_nettype none
// Path: an accepted byte is stored in a queue slot, and the result it causes is then held in the result register.
// Throughput: one byte per cycle; the front takes a byte whenever the
//   two-entry queue has room, the back drains one entry per cycle while the
//   result register is free or being taken.
// Reset: arst_n clears position, match flag, queue and result valid at once;
//   pattern words reset to zero, pattern length to one.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_top
// Scans a byte stream for the first match of a wildcard byte pattern and
// reports its offset, or not-found at the final byte.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_top import wbps_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      last_byte,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           found,
	output logic [31:0]                    match_offset,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic        push;
	scan_item_t  push_item;
	scan_item_t  head;
	logic        pop;
	queue_stat_t q_stat;
	back_stat_t  b_stat;

	wbps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_stat.full),
		.push      (push),
		.push_item (push_item)
	);

	wbps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	wbps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.q_empty      (q_stat.empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset),
		.stat         (b_stat)
	);

`ifndef NO_ASSERTIONS
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0)
		else $error("not-found result with nonzero offset");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("pop from empty queue");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.pop && b_stat.pop_last |=> !b_stat.match_seen)
		else $error("match flag survives final byte");
`endif

endmodule
`default_nettype wire

// ===== test/wildcard_byte_pattern_scan_top_tb.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_top_tb
// Self-checking bench for the wildcard byte pattern scanner. Byte images are
// streamed with random gaps and back-pressure. Every accepted byte goes into
// a cycle-free model of the scan, which queues the found / not-found report
// it implies. Reports from the block are checked against that queue in order.
// ----------------------------------------------------------------------------

class scan_scoreboard;
	typedef struct packed {
		logic        found;
		logic [31:0] offset;
	} scan_report_t;

	logic [wbps_pkg::PATTERN_MAX*8-1:0] pattern_bits;
	wbps_pkg::len_t    length_reg;
	wbps_pkg::window_t window;
	wbps_pkg::pos_t    position;
	bit                matched;
	scan_report_t      expected_reports[$];
	int unsigned       scanned;
	int unsigned       errors;

	function new();
		pattern_bits = '0;
		length_reg   = wbps_pkg::len_t'(1);
		scanned      = 0;
		errors       = 0;
		clear_scan();
	endfunction

	function void clear_scan();
		window   = '0;
		position = '0;
		matched  = 1'b0;
	endfunction

	function void write_reg(logic [wbps_pkg::CFG_INDEX_BITS-1:0] idx, logic [63:0] value);
		case (idx)
		wbps_pkg::REG_PATTERN_0, wbps_pkg::REG_PATTERN_1,
		wbps_pkg::REG_PATTERN_2, wbps_pkg::REG_PATTERN_3: begin
			pattern_bits[64*idx +: 64] = value;
		end
		wbps_pkg::REG_LENGTH: begin
			length_reg = value[wbps_pkg::LEN_BITS-1:0];
		end
		default: begin
		end
		endcase
	endfunction

	// zero counts as one, anything past the window as the whole window
	function int unsigned pattern_span();
		int unsigned n;
		n = length_reg;
		if (n == 0)
			n = 1;
		else if (n > wbps_pkg::PATTERN_MAX)
			n = wbps_pkg::PATTERN_MAX;
		return n;
	endfunction

	function int unsigned pending();
		return expected_reports.size();
	endfunction

	function void note_byte(logic [7:0] value, logic last);
		int unsigned     n;
		int unsigned     k;
		longint unsigned at;
		bit              hit;
		logic [7:0]      want;
		scan_report_t    r;
		n   = pattern_span();
		at  = position;
		hit = 1'b0;
		scanned++;
		if (!matched) begin
			window = {window[wbps_pkg::PATTERN_MAX-2:0], value};
			if (at + 1 >= n) begin
				hit = 1'b1;
				for (k = 0; k < n; k++) begin
					want = pattern_bits[8*k +: 8];
					// pattern byte 0 lines up with the oldest byte of the span
					if (want != window[n-1-k] && want != wbps_pkg::WILDCARD_BYTE)
						hit = 1'b0;
				end
			end
			if (position != '1)
				position++;
		end
		if (hit) begin
			r.found  = 1'b1;
			r.offset = 32'(at + 1 - n);
			expected_reports.push_back(r);
			matched = 1'b1;
			if (last)
				clear_scan();
		end else if (last) begin
			if (!matched) begin
				r.found  = 1'b0;
				r.offset = '0;
				expected_reports.push_back(r);
			end
			clear_scan();
		end
	endfunction

	function void complain(string msg);
		errors++;
		if (errors <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	function void check_report(logic found_bit, logic [31:0] offset);
		scan_report_t want;
		if (expected_reports.size() == 0) begin
			complain($sformatf("report with none outstanding: found=%0b offset=%0d",
				found_bit, offset));
		end else begin
			want = expected_reports.pop_front();
			if (found_bit !== want.found)
				complain($sformatf("found: expected %0b, got %0b", want.found, found_bit));
			if (offset !== want.offset)
				complain($sformatf("match_offset: expected %0d, got %0d",
					want.offset, offset));
		end
	endfunction

	function void leftover();
		if (expected_reports.size() != 0)
			complain($sformatf("%0d expected reports never arrived",
				expected_reports.size()));
	endfunction
endclass

module wildcard_byte_pattern_scan_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wbps_pkg::*;

	localparam int SCAN_TARGET    = 1450;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef logic [7:0] image_t[$];
	typedef enum {SCAN_PLANTED, SCAN_NEAR_MISS, SCAN_NOISE, SCAN_SHORT} scan_kind_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic [7:0]                data_byte = '0;
	logic                      last_byte = 1'b0;
	logic                      out_ready = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                      in_ready;
	logic                      out_valid;
	logic                      found;
	logic [31:0]               match_offset;

	bit                        no_idling    = 1'b0;
	bit                        hold_outputs = 1'b0;
	bit                        wide_bytes   = 1'b1;
	logic [31:0]               alphabet     = '0;
	logic [PATTERN_MAX*8-1:0]  pattern      = '0;
	scan_scoreboard            sb           = new();

	wildcard_byte_pattern_scan_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] fill_byte();
		return wide_bytes ? 8'($urandom) : alphabet[8*$urandom_range(0, 3) +: 8];
	endfunction

	function automatic logic [PATTERN_MAX*8-1:0] draw_pattern();
		logic [PATTERN_MAX*8-1:0] pat;
		int unsigned              k;
		for (k = 0; k < PATTERN_MAX; k++)
			pat[8*k +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD_BYTE : fill_byte();
		return pat;
	endfunction

	function automatic image_t build_scan(input scan_kind_t kind);
		image_t      img;
		int unsigned n;
		int unsigned k;
		int unsigned at;
		n = sb.pattern_span();
		case (kind)
		SCAN_NOISE: begin
			repeat ($urandom_range(1, 24)) img.push_back(fill_byte());
		end
		SCAN_SHORT: begin
			repeat (n > 1 ? $urandom_range(1, n - 1) : 1) img.push_back(fill_byte());
		end
		default: begin
			repeat ($urandom_range(0, 12)) img.push_back(fill_byte());
			at = img.size();
			for (k = 0; k < n; k++)
				img.push_back(pattern[8*k +: 8] == WILDCARD_BYTE ? fill_byte()
					: pattern[8*k +: 8]);
			// spoil one fixed byte, unless the drawn one is a wildcard, so the span just fails
			if (kind == SCAN_NEAR_MISS) begin
				k = $urandom_range(0, n - 1);
				if (pattern[8*k +: 8] != WILDCARD_BYTE)
					img[at+k] = img[at+k] ^ 8'(1 << $urandom_range(0, 7));
			end
			repeat ($urandom_range(0, 6)) img.push_back(fill_byte());
		end
		endcase
		return img;
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic configure(input logic [PATTERN_MAX*8-1:0] pat,
			input logic [LEN_BITS-1:0] len);
		// unmapped indexes must leave everything alone
		if ($urandom_range(0, 1))
			write_reg(CFG_INDEX_BITS'($urandom_range(REG_LENGTH + 1, (1 << CFG_INDEX_BITS) - 1)),
				{32'($urandom), 32'($urandom)});
		write_reg(REG_PATTERN_0, pat[63:0]);
		write_reg(REG_PATTERN_1, pat[127:64]);
		write_reg(REG_PATTERN_2, pat[191:128]);
		write_reg(REG_PATTERN_3, pat[255:192]);
		// upper bits of the length word are junk and must be dropped
		write_reg(REG_LENGTH, {32'($urandom), 26'($urandom), len});
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] value, input logic last);
		int unsigned gap;
		gap = no_idling ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= value;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(value, last);
	endtask

	task automatic send_image(input image_t img, input bit finish);
		foreach (img[k])
			send_byte(img[k], finish && (k == img.size() - 1));
	endtask

	// drop the request line and let the block drain before touching registers
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_outputs) begin
				stall        = HOLD_CYCLES;
				hold_outputs = 1'b0;
			end else begin
				stall = no_idling ? 0 : $urandom_range(0, 6);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_report(found, match_offset);
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("wildcard_byte_pattern_scan_top verification failed");
		$finish;
	end

	initial begin
		image_t              img;
		int unsigned         pick;
		logic [LEN_BITS-1:0] len;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset pattern is a single 0x00; the final byte completes it
		img = {8'hFF, 8'h00};
		send_image(img, 1'b1);
		settle();

		// length zero acts as one; first byte hits, the rest are ignored
		pattern = {PATTERN_MAX{WILDCARD_BYTE}};
		configure(pattern, '0);
		img = {8'hAB, 8'h12, 8'h34};
		send_image(img, 1'b1);
		settle();

		pattern        = draw_pattern();
		pattern[15:0]  = 16'hFF00;
		configure(pattern, 6'd2);
		img = {8'hFF, 8'h00, 8'hFF};
		send_image(img, 1'b1);
		settle();

		// oversized length clamps to the window; image too short for it
		pattern = draw_pattern();
		configure(pattern, '1);
		img = {8'h00, 8'hFF, 8'h55};
		send_image(img, 1'b1);
		settle();

		// new pattern lands half way through an image
		pattern[7:0] = 8'h5A;
		configure(pattern, 6'd1);
		img = {8'h00, 8'h11};
		send_image(img, 1'b0);
		settle();
		pattern[15:0] = 16'h2211;
		configure(pattern, 6'd2);
		img = {8'h11, 8'h22, 8'h33};
		send_image(img, 1'b1);
		settle();

		pattern[23:0] = {8'h03, WILDCARD_BYTE, 8'h01};
		configure(pattern, 6'd3);
		img = {8'h01, 8'h02, 8'h04, 8'h03};
		send_image(img, 1'b1);
		settle();

		// one-byte images back to back while the receiver sits on its ready
		pattern[7:0] = 8'h5A;
		configure(pattern, 6'd1);
		no_idling    = 1'b1;
		hold_outputs = 1'b1;
		repeat (30) send_byte($urandom_range(0, 1) ? 8'h5A : 8'($urandom), 1'b1);
		settle();

		while (sb.scanned < SCAN_TARGET) begin
			no_idling  = ($urandom_range(0, 3) == 0);
			wide_bytes = $urandom_range(0, 1);
			alphabet   = $urandom;
			pattern    = draw_pattern();
			pick       = $urandom_range(0, 19);
			len = (pick == 0) ? 6'd0
				: (pick == 1) ? 6'($urandom_range(PATTERN_MAX + 1, 63))
				: (pick < 4)  ? 6'(PATTERN_MAX)
				: (pick < 7)  ? 6'($urandom_range(9, PATTERN_MAX - 1))
				: 6'($urandom_range(1, 8));
			configure(pattern, len);
			repeat ($urandom_range(2, 6)) begin
				pick = $urandom_range(0, 9);
				img = build_scan(pick < 6 ? SCAN_PLANTED : pick < 8 ? SCAN_NEAR_MISS
					: pick < 9 ? SCAN_NOISE : SCAN_SHORT);
				send_image(img, 1'b1);
			end
			// sometimes carry an open image over the next register update
			if ($urandom_range(0, 3) == 0) begin
				img = build_scan(SCAN_NOISE);
				send_image(img, 1'b0);
			end
			settle();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.leftover();
		if (sb.errors == 0)
			$display("wildcard_byte_pattern_scan_top verification clean");
		else
			$display("wildcard_byte_pattern_scan_top verification failed");
		$finish;
	end

endmodule
